// ----- rtl/srr_pkg.sv -----
// Shared types and constants for the sequence reorder release block.
// No dependencies; imported by srr_table, sequence_reorder_release and the testbench.
`default_nettype none

package srr_pkg;

	localparam int TABLE_DEPTH_DEF = 32;
	localparam int TAG_WIDTH_DEF   = 16;

	localparam int ID_W       = 32;
	localparam int LIMIT_W    = 6;
	localparam int CMD_W      = 2;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// commands
	localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STORE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DRAIN    = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_RELEASED   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DRAIN_DONE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STORED     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_STALE      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FULL       = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DISPATCH   = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 1'b1;

	localparam logic [ID_W-1:0]    WINDOW_RST = 32'd4;
	localparam logic [LIMIT_W-1:0] LIMIT_RST  = 6'd32;

	// sequencer to table
	typedef struct packed {
		logic start;    // begin a sweep over all entries
		logic bounded;  // min search restricted to key < id < bound
		logic purge;    // drop entries below key during the sweep
		logic wr_en;
		logic clr_en;
	} tbl_ctl_t;

	// table to sequencer
	typedef struct packed {
		logic done;        // sweep finished, accumulators final
		logic hit;         // a valid entry matched key
		logic free;        // a free slot exists
		logic best_found;  // min search found an entry
	} tbl_stat_t;

endpackage

`default_nettype wire

// ----- rtl/srr_table.sv -----
// Entry table: id/tag memory, valid bits and one compare unit swept over entries.
// Depends on srr_pkg.
`default_nettype none

module srr_table
	import srr_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int TAG_WIDTH   = TAG_WIDTH_DEF,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tbl_ctl_t            ctl,
	input  wire [ID_W-1:0]      key,
	input  wire [ID_W-1:0]      bound,
	input  wire [AW-1:0]        wr_idx,
	input  wire [ID_W-1:0]      wr_id,
	input  wire [TAG_WIDTH-1:0] wr_tag,
	input  wire [AW-1:0]        clr_idx,
	output tbl_stat_t           stat,
	output logic [AW-1:0]       hit_idx,
	output logic [TAG_WIDTH-1:0] hit_tag,
	output logic [AW-1:0]       free_idx,
	output logic [AW-1:0]       best_idx,
	output logic [ID_W-1:0]     best_id,
	output logic [CW-1:0]       count
);

	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

	logic [ID_W-1:0]      id_mem  [TABLE_DEPTH];
	logic [TAG_WIDTH-1:0] tag_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;

	logic [AW-1:0]        ptr_q;
	logic                 issue_q;
	logic                 pipe_s1;
	logic [AW-1:0]        idx_s1;
	logic [ID_W-1:0]      rd_id_s1;
	logic [TAG_WIDTH-1:0] rd_tag_s1;

	logic                 bounded_q, purge_q;
	logic                 done_q, hit_q, free_q, best_found_q;
	logic [AW-1:0]        hit_idx_q, free_idx_q, best_idx_q;
	logic [TAG_WIDTH-1:0] hit_tag_q;
	logic [ID_W-1:0]      best_id_q;
	logic [CW-1:0]        count_q;

	logic ent_v, eq_key, lt_key, in_rng, lt_best;

	always_comb begin
		ent_v   = vld_q[idx_s1];
		eq_key  = (rd_id_s1 == key);
		lt_key  = (rd_id_s1 < key);
		in_rng  = !bounded_q || ((rd_id_s1 > key) && (rd_id_s1 < bound));
		lt_best = (rd_id_s1 < best_id_q);
	end

	// memory: one write port, one registered read port driven by the sweep pointer
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			id_mem[wr_idx]  <= wr_id;
			tag_mem[wr_idx] <= wr_tag;
		end
		if (issue_q) begin
			rd_id_s1  <= id_mem[ptr_q];
			rd_tag_s1 <= tag_mem[ptr_q];
			idx_s1    <= ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctl.wr_en)
				vld_q[wr_idx] <= 1'b1;
			if (ctl.clr_en)
				vld_q[clr_idx] <= 1'b0;
			if (pipe_s1 && purge_q && ent_v && lt_key)
				vld_q[idx_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			issue_q      <= 1'b0;
			pipe_s1      <= 1'b0;
			done_q       <= 1'b0;
			bounded_q    <= 1'b0;
			purge_q      <= 1'b0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			best_found_q <= 1'b0;
			count_q      <= '0;
		end else begin
			pipe_s1 <= issue_q;
			done_q  <= pipe_s1 && (idx_s1 == LAST_IDX);
			if (ctl.start) begin
				ptr_q        <= '0;
				issue_q      <= 1'b1;
				bounded_q    <= ctl.bounded;
				purge_q      <= ctl.purge;
				hit_q        <= 1'b0;
				free_q       <= 1'b0;
				best_found_q <= 1'b0;
				count_q      <= '0;
			end else begin
				if (issue_q) begin
					if (ptr_q == LAST_IDX)
						issue_q <= 1'b0;
					else
						ptr_q <= ptr_q + AW'(1);
				end
				if (pipe_s1) begin
					if (ent_v && eq_key && !hit_q)
						hit_q <= 1'b1;
					if (!ent_v && !free_q)
						free_q <= 1'b1;
					if (ent_v && in_rng)
						best_found_q <= 1'b1;
					if (ent_v && !(purge_q && lt_key))
						count_q <= count_q + CW'(1);
				end
			end
		end
	end

	// accumulator payloads, qualified by the flags above
	always_ff @(posedge clk) begin
		if (pipe_s1 && !ctl.start) begin
			if (ent_v && eq_key && !hit_q) begin
				hit_idx_q <= idx_s1;
				hit_tag_q <= rd_tag_s1;
			end
			if (!ent_v && !free_q)
				free_idx_q <= idx_s1;
			// strict compare keeps the lowest index on equal ids
			if (ent_v && in_rng && (!best_found_q || lt_best)) begin
				best_idx_q <= idx_s1;
				best_id_q  <= rd_id_s1;
			end
		end
	end

	always_comb begin
		stat.done       = done_q;
		stat.hit        = hit_q;
		stat.free       = free_q;
		stat.best_found = best_found_q;
	end

	assign hit_idx  = hit_idx_q;
	assign hit_tag  = hit_tag_q;
	assign free_idx = free_idx_q;
	assign best_idx = best_idx_q;
	assign best_id  = best_id_q;
	assign count    = count_q;

endmodule

`default_nettype wire

// ----- rtl/sequence_reorder_release.sv -----
// Sequence reorder release: top level with command sequencer and output register.
// Depends on srr_pkg and srr_table.
//
// Items enter on item_valid/item_stall with command, seq_id and payload; results
// leave on result_valid/result_stall with kind, frame_id_out, payload_out and last.
// Every item but an unknown command gives one or more results; last marks the final one.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must do so only
// while the block is idle, which the block itself does not enforce.
//
// One item is taken at a time; item_stall is high until the sequencer is back in idle.
// All table work is done by sweeping the entries through a single compare unit, one
// entry a cycle. Steps from one accepted item to the next:
//   dispatch, stale result: the result is registered, then the sequencer returns to idle
//   store:                  one sweep, then the result
//   drain:                  one sweep for the first id if there is no next id yet,
//                           one sweep per release or skip plus one that ends the search,
//                           a purge sweep, one sweep per eviction, a result per release,
//                           then the final check, the result and the return to idle
// A stalled receiver holds the result register; the sequencer waits before each release
// and before the final result, so nothing is lost.
// Reset clears all valid bits and tracking state at once; no clearing pass is needed.
// Registers reset to a window of 4 and a pending limit of 32.
`default_nettype none

module sequence_reorder_release
	import srr_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   item_valid,
	output logic                  item_stall,
	input  wire [CMD_W-1:0]       command,
	input  wire [ID_W-1:0]        seq_id,
	input  wire [TAG_WIDTH-1:0]   payload,
	output logic                  result_valid,
	input  wire                   result_stall,
	output logic [KIND_W-1:0]     kind,
	output logic [ID_W-1:0]       frame_id_out,
	output logic [TAG_WIDTH-1:0]  payload_out,
	output logic                  last,
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_STORE_SCAN = 4'd1;
	localparam logic [3:0] S_OUT        = 4'd2;
	localparam logic [3:0] S_MIN_SCAN   = 4'd3;
	localparam logic [3:0] S_LOOP_SCAN  = 4'd4;
	localparam logic [3:0] S_REL        = 4'd5;
	localparam logic [3:0] S_PURGE_SCAN = 4'd6;
	localparam logic [3:0] S_EVICT_CHK  = 4'd7;
	localparam logic [3:0] S_EVICT_SCAN = 4'd8;

	logic [3:0] state_q, state_d;

	logic [ID_W-1:0]    window_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [ID_W-1:0]    ne_q, ld_q;
	logic               ne_valid_q, ld_valid_q;

	logic [ID_W-1:0]      fid_q;
	logic [TAG_WIDTH-1:0] tag_q;
	logic [ID_W-1:0]      target_q;
	logic [CW-1:0]        cnt_q;
	logic [KIND_W-1:0]    pend_kind_q;
	logic [ID_W-1:0]      pend_id_q;

	logic                 res_valid_q;
	logic [KIND_W-1:0]    kind_q;
	logic [ID_W-1:0]      fid_out_q;
	logic [TAG_WIDTH-1:0] pay_out_q;
	logic                 last_q;

	tbl_ctl_t             ctl;
	tbl_stat_t            stat;
	logic [ID_W-1:0]      key;
	logic [AW-1:0]        hit_idx, free_idx, best_idx, clr_idx, wr_idx;
	logic [TAG_WIDTH-1:0] hit_tag;
	logic [ID_W-1:0]      best_id;
	logic [CW-1:0]        tbl_count;

	logic               in_acc, out_free, out_load, skip, evict_need, stale;
	logic [LIMIT_W-1:0] lim;

	assign item_stall = (state_q != S_IDLE);
	assign in_acc     = item_valid && !item_stall;
	assign out_free   = !res_valid_q || !result_stall;
	assign out_load   = ((state_q == S_OUT) || (state_q == S_REL)) && out_free;
	assign stale      = ne_valid_q && (seq_id < ne_q);

	// skip a missing id while latest dispatched runs more than the window ahead
	assign skip       = ld_valid_q && (ld_q > ne_q) && ((ld_q - ne_q) > window_q);
	assign lim        = (limit_q == '0) ? LIMIT_W'(1) : limit_q;
	assign evict_need = (LIMIT_W'(cnt_q) > lim);

	assign key     = (state_q == S_STORE_SCAN) ? fid_q : ne_q;
	assign wr_idx  = stat.hit ? hit_idx : free_idx;
	assign clr_idx = (state_q == S_REL) ? hit_idx : best_idx;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (command)
						CMD_DISPATCH: state_d = S_OUT;
						CMD_STORE: begin
							if (stale) begin
								state_d = S_OUT;
							end else begin
								ctl.start = 1'b1;
								state_d   = S_STORE_SCAN;
							end
						end
						CMD_DRAIN: begin
							ctl.start   = 1'b1;
							ctl.bounded = ne_valid_q;
							state_d     = ne_valid_q ? S_LOOP_SCAN : S_MIN_SCAN;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_STORE_SCAN: begin
				if (stat.done) begin
					ctl.wr_en = stat.hit || stat.free;
					state_d   = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			S_MIN_SCAN: begin
				if (stat.done) begin
					ctl.start = 1'b1;
					if (stat.best_found) begin
						ctl.bounded = 1'b1;
						state_d     = S_LOOP_SCAN;
					end else begin
						state_d = S_PURGE_SCAN;
					end
				end
			end
			S_LOOP_SCAN: begin
				if (stat.done) begin
					if (stat.hit) begin
						state_d = S_REL;
					end else if (skip) begin
						ctl.start   = 1'b1;
						ctl.bounded = 1'b1;
					end else begin
						ctl.start = 1'b1;
						ctl.purge = 1'b1;
						state_d   = S_PURGE_SCAN;
					end
				end
			end
			S_REL: begin
				if (out_free) begin
					ctl.clr_en  = 1'b1;
					ctl.start   = 1'b1;
					ctl.bounded = 1'b1;
					state_d     = S_LOOP_SCAN;
				end
			end
			S_PURGE_SCAN: begin
				if (stat.done)
					state_d = S_EVICT_CHK;
			end
			S_EVICT_CHK: begin
				if (evict_need) begin
					ctl.start = 1'b1;
					state_d   = S_EVICT_SCAN;
				end else begin
					state_d = S_OUT;
				end
			end
			S_EVICT_SCAN: begin
				if (stat.done) begin
					ctl.clr_en = 1'b1;
					state_d    = S_EVICT_CHK;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			window_q    <= WINDOW_RST;
			limit_q     <= LIMIT_RST;
			ne_q        <= '0;
			ne_valid_q  <= 1'b0;
			ld_q        <= '0;
			ld_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WINDOW: window_q <= cfg_data[ID_W-1:0];
					REG_LIMIT:  limit_q  <= cfg_data[LIMIT_W-1:0];
					default:    window_q <= window_q;
				endcase
			end
			if (in_acc && (command == CMD_DISPATCH)) begin
				if (!ld_valid_q || (seq_id > ld_q))
					ld_q <= seq_id;
				ld_valid_q <= 1'b1;
			end
			if ((state_q == S_MIN_SCAN) && stat.done && stat.best_found) begin
				ne_q       <= best_id;
				ne_valid_q <= 1'b1;
			end
			if ((state_q == S_LOOP_SCAN) && stat.done && !stat.hit && skip)
				ne_q <= stat.best_found ? best_id : target_q;
			if ((state_q == S_REL) && out_free)
				ne_q <= ne_q + 32'd1;   // wraps past the top id
			if (out_load)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			fid_q     <= seq_id;
			tag_q     <= payload;
			target_q  <= ld_q - window_q;
			pend_id_q <= seq_id;
			pend_kind_q <= (command == CMD_DISPATCH) ? KIND_DISPATCH : KIND_STALE;
		end
		if ((state_q == S_STORE_SCAN) && stat.done)
			pend_kind_q <= (stat.hit || stat.free) ? KIND_STORED : KIND_FULL;
		if ((state_q == S_PURGE_SCAN) && stat.done)
			cnt_q <= tbl_count;
		if ((state_q == S_EVICT_SCAN) && stat.done)
			cnt_q <= cnt_q - CW'(1);
		if ((state_q == S_EVICT_CHK) && !evict_need) begin
			pend_kind_q <= KIND_DRAIN_DONE;
			pend_id_q   <= ne_valid_q ? ne_q : '0;
		end
		if (out_load) begin
			if (state_q == S_REL) begin
				kind_q    <= KIND_RELEASED;
				fid_out_q <= ne_q;
				pay_out_q <= hit_tag;
				last_q    <= 1'b0;
			end else begin
				kind_q    <= pend_kind_q;
				fid_out_q <= pend_id_q;
				pay_out_q <= '0;
				last_q    <= 1'b1;
			end
		end
	end

	srr_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.TAG_WIDTH   (TAG_WIDTH)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.key      (key),
		.bound    (target_q),
		.wr_idx   (wr_idx),
		.wr_id    (fid_q),
		.wr_tag   (tag_q),
		.clr_idx  (clr_idx),
		.stat     (stat),
		.hit_idx  (hit_idx),
		.hit_tag  (hit_tag),
		.free_idx (free_idx),
		.best_idx (best_idx),
		.best_id  (best_id),
		.count    (tbl_count)
	);

	assign result_valid = res_valid_q;
	assign kind         = kind_q;
	assign frame_id_out = fid_out_q;
	assign payload_out  = pay_out_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// ----- tb/srr_checker.sv -----
`timescale 1ns / 100ps
// Checker for sequence_reorder_release: watches both channels and the register port,
// predicts every result and compares it field by field. Depends on srr_pkg.

module srr_checker
	import srr_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   item_valid,
	input  wire                   item_stall,
	input  wire [CMD_W-1:0]       command,
	input  wire [ID_W-1:0]        seq_id,
	input  wire [TAG_WIDTH-1:0]   payload,
	input  wire                   result_valid,
	input  wire                   result_stall,
	input  wire [KIND_W-1:0]      kind,
	input  wire [ID_W-1:0]        frame_id_out,
	input  wire [TAG_WIDTH-1:0]   payload_out,
	input  wire                   last,
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data,
	output int                    fail_count,
	output int                    awaited_count
);

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [ID_W-1:0]      id;
		logic [TAG_WIDTH-1:0] tag;
		logic                 fin;
	} outcome_t;

	// mirror of the block's table and tracking state
	logic                 ent_valid [TABLE_DEPTH];
	logic [ID_W-1:0]      ent_id    [TABLE_DEPTH];
	logic [TAG_WIDTH-1:0] ent_tag   [TABLE_DEPTH];
	logic [ID_W-1:0]      next_id;
	logic                 next_ok;
	logic [ID_W-1:0]      newest_disp;
	logic                 disp_ok;
	logic [ID_W-1:0]      window;
	logic [LIMIT_W-1:0]   limit;

	outcome_t awaited[$];
	outcome_t head;

	function automatic void note(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
			input logic [TAG_WIDTH-1:0] tag, input logic fin);
		outcome_t o;
		o.kind = k;
		o.id   = id;
		o.tag  = tag;
		o.fin  = fin;
		awaited = {awaited, o};
	endfunction

	function automatic int slot_of(input logic [ID_W-1:0] id);
		int hit;
		hit = -1;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--)
			if (ent_valid[i] && ent_id[i] == id)
				hit = i;
		return hit;
	endfunction

	function automatic int free_slot();
		int hit;
		hit = -1;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--)
			if (!ent_valid[i])
				hit = i;
		return hit;
	endfunction

	function automatic int lowest_slot();
		int best;
		best = -1;
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (ent_valid[i] && (best < 0 || ent_id[i] < ent_id[best]))
				best = i;
		return best;
	endfunction

	function automatic void store_result(input logic [ID_W-1:0] id,
			input logic [TAG_WIDTH-1:0] tag);
		int slot;
		if (next_ok && id < next_id) begin
			note(KIND_STALE, id, '0, 1'b1);
		end else begin
			slot = slot_of(id);
			if (slot < 0)
				slot = free_slot();
			if (slot < 0) begin
				note(KIND_FULL, id, '0, 1'b1);
			end else begin
				ent_valid[slot] = 1'b1;
				ent_id[slot]    = id;
				ent_tag[slot]   = tag;
				note(KIND_STORED, id, '0, 1'b1);
			end
		end
	endfunction

	function automatic void predict_drain();
		int k, best, count, cap;
		logic done;
		logic [ID_W-1:0] skip_to;
		if (!next_ok) begin
			k = lowest_slot();
			if (k >= 0) begin
				next_id = ent_id[k];
				next_ok = 1'b1;
			end
		end
		if (next_ok) begin
			done = 1'b0;
			while (!done) begin
				k = slot_of(next_id);
				if (k >= 0) begin
					note(KIND_RELEASED, ent_id[k], ent_tag[k], 1'b0);
					ent_valid[k] = 1'b0;
					next_id = next_id + 1'b1;   // wraps at the top id
				end else if (disp_ok && newest_disp > next_id &&
						(newest_disp - next_id) > window) begin
					// jump over the gap in one go
					skip_to = newest_disp - window;
					best = -1;
					for (int i = 0; i < TABLE_DEPTH; i++)
						if (ent_valid[i] && ent_id[i] > next_id && ent_id[i] < skip_to &&
								(best < 0 || ent_id[i] < ent_id[best]))
							best = i;
					next_id = (best >= 0) ? ent_id[best] : skip_to;
				end else begin
					done = 1'b1;
				end
			end
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (ent_valid[i] && ent_id[i] < next_id)
					ent_valid[i] = 1'b0;
		end
		cap = (limit == 0) ? 1 : int'(limit);
		count = 0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (ent_valid[i])
				count++;
		while (count > cap) begin
			ent_valid[lowest_slot()] = 1'b0;
			count--;
		end
		note(KIND_DRAIN_DONE, next_ok ? next_id : '0, '0, 1'b1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				ent_valid[i] = 1'b0;
				ent_id[i]    = '0;
				ent_tag[i]   = '0;
			end
			next_id     = '0;
			next_ok     = 1'b0;
			newest_disp = '0;
			disp_ok     = 1'b0;
			window      = WINDOW_RST;
			limit       = LIMIT_RST;
			awaited.delete();
			fail_count    = 0;
			awaited_count <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WINDOW)
					window = cfg_data[ID_W-1:0];
				else if (cfg_index == REG_LIMIT)
					limit = cfg_data[LIMIT_W-1:0];
			end

			if (result_valid && !result_stall) begin
				if (awaited.size() == 0) begin
					$error("unexpected result: kind %0d, frame_id_out %h", kind, frame_id_out);
					fail_count++;
				end else begin
					head = awaited.pop_front();
					if (kind !== head.kind) begin
						$error("kind: expected %0d, actual %0d", head.kind, kind);
						fail_count++;
					end
					if (frame_id_out !== head.id) begin
						$error("frame_id_out: expected %h, actual %h", head.id, frame_id_out);
						fail_count++;
					end
					if (payload_out !== head.tag) begin
						$error("payload_out: expected %h, actual %h", head.tag, payload_out);
						fail_count++;
					end
					if (last !== head.fin) begin
						$error("last: expected %0d, actual %0d", head.fin, last);
						fail_count++;
					end
				end
			end

			if (item_valid && !item_stall) begin
				case (command)
				CMD_DISPATCH: begin
					if (!disp_ok || seq_id > newest_disp)
						newest_disp = seq_id;
					disp_ok = 1'b1;
					note(KIND_DISPATCH, seq_id, '0, 1'b1);
				end
				CMD_STORE: store_result(seq_id, payload);
				CMD_DRAIN: predict_drain();
				default: ;   // unknown command leaves no trace
				endcase
			end
			awaited_count <= awaited.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for sequence_reorder_release: clock, reset, item stimulus, receiver
// stalls, watchdog and verdict. Depends on srr_pkg, srr_checker and the block itself.

module tb;
	import srr_pkg::*;

	localparam int TAG_W       = TAG_WIDTH_DEF;
	localparam int SETTLE      = 2 * (TABLE_DEPTH_DEF + 2);
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 20000;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	logic [CMD_W-1:0]      command;
	logic [ID_W-1:0]       seq_id;
	logic [TAG_W-1:0]      payload;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [KIND_W-1:0]     kind;
	logic [ID_W-1:0]       frame_id_out;
	logic [TAG_W-1:0]      payload_out;
	logic                  last;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    awaited_count;

	logic [ID_W-1:0] top_id;
	logic [ID_W-1:0] in_flight[$];   // dispatched ids whose result is still to be sent
	logic            lose_next  = 1'b0;
	logic            high_noise = 1'b0;
	logic            calm       = 1'b0;
	int              hold_reqs  = 0;
	int              hold_seen  = 0;
	int              hold_left  = 0;
	int              quiet      = 0;

	sequence_reorder_release u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.seq_id       (seq_id),
		.payload      (payload),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.frame_id_out (frame_id_out),
		.payload_out  (payload_out),
		.last         (last),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	srr_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.command       (command),
		.seq_id        (seq_id),
		.payload       (payload),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.kind          (kind),
		.frame_id_out  (frame_id_out),
		.payload_out   (payload_out),
		.last          (last),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.awaited_count (awaited_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !calm && ($urandom_range(0, 99) < 16);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("sequence_reorder_release verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
			input logic [TAG_W-1:0] tag);
		while (!calm && $urandom_range(0, 99) < 16) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		command    <= cmd;
		seq_id     <= id;
		payload    <= tag;
		do
			@(posedge clk);
		while (item_stall);
	endtask

	// stop offering items and wait until the block has gone quiet
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (awaited_count != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_regs(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] lim);
		settle();
		write_reg(REG_WINDOW, win);
		write_reg(REG_LIMIT, lim);
	endtask

	// frames dispatched in order, results back shuffled with some lost or repeated,
	// drains in between, and a share of stale, late and unknown items
	task automatic traffic(input int count);
		int r, pick;
		logic [ID_W-1:0] id, back;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			back = $urandom_range(0, 48);
			back = (top_id > back) ? top_id - back : '0;
			if (r < 30) begin
				top_id = (top_id >= 32'hFFFF_FFFD) ? 32'hFFFF_FFFF :
					top_id + 1 + ($urandom_range(0, 9) == 0);
				if (!lose_next && $urandom_range(0, 99) >= 8)
					in_flight = {in_flight, top_id};
				lose_next = 1'b0;
				send_item(CMD_DISPATCH, top_id, TAG_W'($urandom()));
			end else if (r < 70 && in_flight.size() != 0) begin
				pick = $urandom_range(0, in_flight.size() - 1);
				id = in_flight[pick];
				if ($urandom_range(0, 99) < 88)
					in_flight.delete(pick);
				send_item(CMD_STORE, id, TAG_W'($urandom()));
			end else if (r < 86) begin
				send_item(CMD_DRAIN, $urandom(), TAG_W'($urandom()));
			end else begin
				case ($urandom_range(0, 3))
				0: send_item(CMD_STORE, back, TAG_W'($urandom()));
				1: send_item(CMD_DISPATCH, back, TAG_W'($urandom()));
				2: send_item(CMD_UNKNOWN, $urandom(), TAG_W'($urandom()));
				default: begin
					id = high_noise ? $urandom() : top_id + $urandom_range(1, 40);
					send_item(CMD_STORE, id, TAG_W'($urandom()));
				end
				endcase
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		command    = CMD_DISPATCH;
		seq_id     = '0;
		payload    = '0;
		cfg_we     = 1'b0;
		cfg_index  = REG_WINDOW;
		cfg_data   = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// directed part, registers at reset values
		send_item(CMD_DRAIN, '0, '0);               // empty table, no next id yet
		send_item(CMD_UNKNOWN, '1, '1);
		send_item(CMD_DISPATCH, '0, '0);
		send_item(CMD_STORE, 32'd5, 16'hFFFF);
		send_item(CMD_STORE, 32'd5, 16'h1234);      // overwrite same id
		send_item(CMD_STORE, 32'd7, 16'h0000);
		send_item(CMD_DRAIN, '1, '1);               // latest dispatched below next: no skip
		send_item(CMD_STORE, 32'd3, 16'h00A5);      // stale
		send_item(CMD_DISPATCH, 32'd12, 16'hFFFF);
		send_item(CMD_DRAIN, '0, '0);               // gap skipped, 7 released
		send_item(CMD_STORE, 32'd9, 16'h5A5A);
		send_item(CMD_STORE, 32'd10, 16'hA5A5);
		send_item(CMD_STORE, 32'd11, 16'h0F0F);
		settle();
		write_reg(REG_LIMIT, 32'd1);
		send_item(CMD_DRAIN, '0, '0);               // evicts down to one entry
		settle();
		write_reg(REG_LIMIT, 32'd0);                // zero behaves as one
		send_item(CMD_STORE, 32'd12, 16'hC3C3);
		send_item(CMD_DRAIN, '0, '0);
		settle();
		write_reg(REG_WINDOW, 32'd0);
		send_item(CMD_DRAIN, '0, '0);
		top_id = 32'd12;

		// random part
		set_regs(32'd4, 32'd32);
		traffic(12);
		hold_reqs++;                                // receiver holds off, block backs up
		traffic(98);

		set_regs(32'd0, 32'd1);
		calm = 1'b1;
		traffic(60);
		calm = 1'b0;

		// a lost first frame that is never skipped: the table fills up
		set_regs(32'hFFFF_FFFF, 32'd63);
		lose_next = 1'b1;
		traffic(110);

		set_regs($urandom_range(0, 8), 32'd0);
		traffic(60);

		set_regs($urandom(), {(CFG_DATA_W - LIMIT_W)'($urandom()),
			LIMIT_W'($urandom_range(2, 31))});
		traffic(30);
		settle();
		traffic(30);

		// ids near the top of the range
		set_regs(32'd4, 32'd32);
		in_flight.delete();
		top_id = 32'hFFFF_FFE7;
		high_noise = 1'b1;
		traffic(70);

		// release at the top id, so next expected wraps round
		set_regs(32'd0, 32'd32);
		send_item(CMD_DISPATCH, 32'hFFFF_FFFF, TAG_W'($urandom()));
		send_item(CMD_STORE, 32'hFFFF_FFFF, TAG_W'($urandom()));
		send_item(CMD_DRAIN, $urandom(), TAG_W'($urandom()));
		settle();

		if (fail_count == 0)
			$display("sequence_reorder_release verification clean");
		else
			$display("sequence_reorder_release verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/srr_pkg.sv
rtl/srr_table.sv
rtl/sequence_reorder_release.sv
tb/srr_checker.sv
tb/tb.sv
